[design/assert_macros.svh]
// Assertion macros used by the checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, idle during reset.
`define FDR_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("fresnel reflectance check failed");

// Implication into the next cycle, idle during reset.
`define FDR_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("fresnel reflectance check failed");

// Implication into the next cycle, active during reset.
`define FDR_ASSERT_RST(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) (pre) |=> (post)) \
        else $error("fresnel reflectance check failed");

`endif

[design/fdr_pkg.sv]
`default_nettype none
package fdr_pkg;

    localparam int VEC_FRAC_BITS = 14;
    // shift that brings the dot product to Q30; positive is a right shift
    localparam int DOT_SH  = 2 * VEC_FRAC_BITS - 30;
    localparam int SH_R    = (DOT_SH > 0) ? DOT_SH : 0;
    localparam int SH_L    = (DOT_SH < 0) ? -DOT_SH : 0;
    localparam logic [63:0] DOT_RND = (64'd1 << SH_R) >> 1;

    localparam int QDIV_STEPS = 36;
    localparam int SQRT_STEPS = 31;
    localparam int RDIV_STEPS = 31;

    typedef struct packed {
        logic [31:0] rem;
        logic [35:0] quo;
        logic [35:0] dvd;
        logic [31:0] dvs;
    } div_cell_t;

    typedef struct packed {
        logic [32:0] rem;
        logic [30:0] root;
        logic [61:0] rad;
    } sqrt_cell_t;

    typedef struct packed {
        logic        graze;
        logic        ovf;
        logic [30:0] cos_i;
        logic [15:0] ior;
    } side_t;

    // right shift that brings a sum below 2^31
    function automatic logic [4:0] norm_shift(input logic [47:0] den);
        logic [4:0] n;
        n = '0;
        for (int i = 31; i < 48; i++) begin
            if (den[i]) begin
                n = 5'(i - 30);
            end
        end
        return n;
    endfunction

endpackage
`default_nettype wire

[design/fdr_div_cell.sv]
`default_nettype none
module fdr_div_cell (
    input  logic                aclk,
    input  logic                en,
    input  fdr_pkg::div_cell_t  cell_in,
    output fdr_pkg::div_cell_t  cell_out
);
    import fdr_pkg::*;

    div_cell_t   cell_reg;
    div_cell_t   cell_next;
    logic [32:0] trial;
    logic [32:0] diff;

    // one restoring step: bring down the next dividend bit, subtract if it fits
    always_comb begin
        trial = {cell_in.rem, cell_in.dvd[35]};
        diff  = trial - {1'b0, cell_in.dvs};
        cell_next     = cell_in;
        cell_next.dvd = {cell_in.dvd[34:0], 1'b0};
        if (trial >= {1'b0, cell_in.dvs}) begin
            cell_next.rem = diff[31:0];
            cell_next.quo = {cell_in.quo[34:0], 1'b1};
        end else begin
            cell_next.rem = trial[31:0];
            cell_next.quo = {cell_in.quo[34:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule
`default_nettype wire

[design/fdr_sqrt_cell.sv]
`default_nettype none
module fdr_sqrt_cell (
    input  logic                 aclk,
    input  logic                 en,
    input  fdr_pkg::sqrt_cell_t  cell_in,
    output fdr_pkg::sqrt_cell_t  cell_out
);
    import fdr_pkg::*;

    sqrt_cell_t  cell_reg;
    sqrt_cell_t  cell_next;
    logic [34:0] rem_ext;
    logic [34:0] trial;
    logic [34:0] diff;

    // one root digit: bring down two radicand bits, try root*4+1
    always_comb begin
        rem_ext = {cell_in.rem, cell_in.rad[61:60]};
        trial   = {2'b00, cell_in.root, 2'b01};
        diff    = rem_ext - trial;
        cell_next     = cell_in;
        cell_next.rad = {cell_in.rad[59:0], 2'b00};
        if (rem_ext >= trial) begin
            cell_next.rem  = diff[32:0];
            cell_next.root = {cell_in.root[29:0], 1'b1};
        end else begin
            cell_next.rem  = rem_ext[32:0];
            cell_next.root = {cell_in.root[29:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule
`default_nettype wire

[design/fresnel_dielectric_reflectance_top.sv]
// Unpolarized Fresnel reflectance of a dielectric (outside index 1): takes a
// normal and a ray direction (signed Q2.14) and the inside index (Q4.12, zero
// read as the smallest code) and returns reflectance in Q1.16, 65536 meaning
// full reflection (grazing incidence or total internal reflection). The block
// takes one request per clock while s_tready is high and returns results in
// order. The pipeline holds three chains of one-bit cells: 36 cells for the
// sine ratio division, 31 for the transmitted-cosine square root and 31 for
// the two amplitude-ratio divisions that run side by side, plus eight stages
// for products, sums, normalization, squares and the output register.
// The whole pipeline advances when the output register is empty or taken, so
// s_tready falls only while a result waits at m_tvalid with m_tready low.
`default_nettype none
module fresnel_dielectric_reflectance_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // normal_x, normal_y, normal_z, dir_x, dir_y, dir_z, refr_index (16 bits each)
    input  logic [111:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // reflectance [16:0], zero fill [23:17]
    output logic [23:0]  m_tdata
);
    import fdr_pkg::*;

    logic en;

    // input fields
    logic signed [15:0] normal_x, normal_y, normal_z, dir_x, dir_y, dir_z;
    logic        [15:0] refr_index;

    // stage 1: products
    logic               st1_vld_reg;
    logic signed [31:0] st1_p0_reg, st1_p1_reg, st1_p2_reg;
    logic        [15:0] st1_ior_reg;
    logic        [31:0] st1_rr_reg;

    // stage 2: cos_i
    logic               st2_vld_reg;
    logic        [30:0] st2_cos_reg;
    logic        [15:0] st2_ior_reg;
    logic        [31:0] st2_rr_reg;
    logic signed [33:0] dot;
    logic        [33:0] mag;
    logic        [63:0] cos_wide;
    logic        [30:0] cos_sat;

    // stage 3: cos_i squared
    logic               st3_vld_reg;
    logic        [61:0] st3_csq_reg;
    logic        [30:0] st3_cos_reg;
    logic        [15:0] st3_ior_reg;
    logic        [31:0] st3_rr_reg;
    logic        [60:0] sin_sq;

    // sine ratio division chain
    div_cell_t              qdiv_link [QDIV_STEPS+1];
    side_t                  qdiv_side_reg [QDIV_STEPS];
    logic [QDIV_STEPS-1:0]  qdiv_vld_reg;
    side_t                  qdiv_side_in;

    // square root chain
    sqrt_cell_t             sqrt_link [SQRT_STEPS+1];
    side_t                  sqrt_side_reg [SQRT_STEPS];
    logic [SQRT_STEPS-1:0]  sqrt_vld_reg;
    logic [36:0]            cos_t_sq;

    // stage 5: Q42 operands
    logic               st5_vld_reg;
    logic               st5_graze_reg;
    logic        [46:0] st5_a_reg, st5_b_reg, st5_c_reg, st5_d_reg;
    logic        [30:0] cos_t;
    side_t              sq_side;

    // stage 6: numerators and denominators
    logic               st6_vld_reg;
    logic               st6_graze_reg;
    logic        [47:0] st6_num_a_reg, st6_den_a_reg, st6_num_b_reg, st6_den_b_reg;

    // stage 7: normalize shift
    logic               st7_vld_reg;
    logic               st7_graze_reg;
    logic        [47:0] st7_num_a_reg, st7_den_a_reg, st7_num_b_reg, st7_den_b_reg;
    logic        [4:0]  st7_sh_a_reg, st7_sh_b_reg;
    logic        [47:0] sh_num_a, sh_den_a, sh_num_b, sh_den_b;
    logic        [31:0] nm_a, dn_a, nm_b, dn_b;
    logic               ge_a, ge_b;

    // ratio division chains
    div_cell_t              rdiv_a_link [RDIV_STEPS+1];
    div_cell_t              rdiv_b_link [RDIV_STEPS+1];
    logic [RDIV_STEPS-1:0]  rdiv_vld_reg;
    logic [RDIV_STEPS-1:0]  rdiv_graze_reg;

    // stage 8: squares
    logic               st8_vld_reg;
    logic               st8_graze_reg;
    logic        [63:0] st8_sq_a_reg, st8_sq_b_reg;
    logic        [63:0] sum;

    // output register
    logic               m_valid_reg;
    logic        [16:0] m_refl_reg;

    // advance every stage when the output slot frees up
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    assign normal_x   = s_tdata[15:0];
    assign normal_y   = s_tdata[31:16];
    assign normal_z   = s_tdata[47:32];
    assign dir_x      = s_tdata[63:48];
    assign dir_y      = s_tdata[79:64];
    assign dir_z      = s_tdata[95:80];
    assign refr_index = s_tdata[111:96];

    // stage 1: three products of the dot product, index squared
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_vld_reg <= 1'b0;
        end else if (en) begin
            st1_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st1_p0_reg  <= normal_x * dir_x;
            st1_p1_reg  <= normal_y * dir_y;
            st1_p2_reg  <= normal_z * dir_z;
            st1_ior_reg <= (refr_index == 16'd0) ? 16'd1 : refr_index;
            st1_rr_reg  <= ((refr_index == 16'd0) ? 16'd1 : refr_index) *
                           ((refr_index == 16'd0) ? 16'd1 : refr_index);
        end
    end

    // stage 2: sum, magnitude, scale to Q30, saturate to one
    always_comb begin
        dot = 34'(st1_p0_reg) + 34'(st1_p1_reg) + 34'(st1_p2_reg);
        mag = dot[33] ? 34'(-dot) : 34'(dot);
        cos_wide = ((64'(mag) + DOT_RND) >> SH_R) << SH_L;
        cos_sat  = (cos_wide > 64'(1 << 30)) ? 31'(1 << 30) : cos_wide[30:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st2_vld_reg <= 1'b0;
        end else if (en) begin
            st2_vld_reg <= st1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st2_cos_reg <= cos_sat;
            st2_ior_reg <= st1_ior_reg;
            st2_rr_reg  <= st1_rr_reg;
        end
    end

    // stage 3: cos_i squared in Q60
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st3_vld_reg <= 1'b0;
        end else if (en) begin
            st3_vld_reg <= st2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st3_csq_reg <= st2_cos_reg * st2_cos_reg;
            st3_cos_reg <= st2_cos_reg;
            st3_ior_reg <= st2_ior_reg;
            st3_rr_reg  <= st2_rr_reg;
        end
    end

    // sin_i^2 / ior^2: the top 25 bits decide overflow past one, the low 36
    // bits are the quotient bits the chain works out
    assign sin_sq = {1'b1, 60'd0} - st3_csq_reg[60:0];

    always_comb begin
        qdiv_link[0].rem = {7'd0, sin_sq[60:36]};
        qdiv_link[0].quo = '0;
        qdiv_link[0].dvd = sin_sq[35:0];
        qdiv_link[0].dvs = st3_rr_reg;
        qdiv_side_in.graze = (st3_cos_reg == 31'd0);
        qdiv_side_in.ovf   = ({7'd0, sin_sq[60:36]} >= st3_rr_reg);
        qdiv_side_in.cos_i = st3_cos_reg;
        qdiv_side_in.ior   = st3_ior_reg;
    end

    for (genvar g = 0; g < QDIV_STEPS; g++) begin : g_qdiv
        fdr_div_cell u_cell (
            .aclk     (aclk),
            .en       (en),
            .cell_in  (qdiv_link[g]),
            .cell_out (qdiv_link[g+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qdiv_vld_reg <= '0;
        end else if (en) begin
            qdiv_vld_reg <= {qdiv_vld_reg[QDIV_STEPS-2:0], st3_vld_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            qdiv_side_reg[0] <= qdiv_side_in;
            for (int i = 1; i < QDIV_STEPS; i++) begin
                qdiv_side_reg[i] <= qdiv_side_reg[i-1];
            end
        end
    end

    // cos_t^2 = 1 - sin_t^2 in Q36, zero on total internal reflection
    assign cos_t_sq = (37'd1 << 36) - {1'b0, qdiv_link[QDIV_STEPS].quo};

    always_comb begin
        sqrt_link[0].rem  = '0;
        sqrt_link[0].root = '0;
        sqrt_link[0].rad  = qdiv_side_reg[QDIV_STEPS-1].ovf ? 62'd0 :
                            {1'b0, cos_t_sq, 24'd0};
    end

    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
        fdr_sqrt_cell u_cell (
            .aclk     (aclk),
            .en       (en),
            .cell_in  (sqrt_link[g]),
            .cell_out (sqrt_link[g+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sqrt_vld_reg <= '0;
        end else if (en) begin
            sqrt_vld_reg <= {sqrt_vld_reg[SQRT_STEPS-2:0], qdiv_vld_reg[QDIV_STEPS-1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sqrt_side_reg[0] <= qdiv_side_reg[QDIV_STEPS-1];
            for (int i = 1; i < SQRT_STEPS; i++) begin
                sqrt_side_reg[i] <= sqrt_side_reg[i-1];
            end
        end
    end

    assign cos_t   = sqrt_link[SQRT_STEPS].root;
    assign sq_side = sqrt_side_reg[SQRT_STEPS-1];

    // stage 5: index-weighted cosines in Q42
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st5_vld_reg <= 1'b0;
        end else if (en) begin
            st5_vld_reg <= sqrt_vld_reg[SQRT_STEPS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st5_graze_reg <= sq_side.graze;
            st5_a_reg     <= {4'd0, sq_side.cos_i, 12'd0};
            st5_b_reg     <= sq_side.ior * cos_t;
            st5_c_reg     <= sq_side.ior * sq_side.cos_i;
            st5_d_reg     <= {4'd0, cos_t, 12'd0};
        end
    end

    // stage 6: |p - q| and p + q for both polarizations
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st6_vld_reg <= 1'b0;
        end else if (en) begin
            st6_vld_reg <= st5_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st6_graze_reg <= st5_graze_reg;
            st6_num_a_reg <= (st5_a_reg >= st5_b_reg) ? 48'(st5_a_reg - st5_b_reg) :
                                                         48'(st5_b_reg - st5_a_reg);
            st6_den_a_reg <= 48'(st5_a_reg) + 48'(st5_b_reg);
            st6_num_b_reg <= (st5_c_reg >= st5_d_reg) ? 48'(st5_c_reg - st5_d_reg) :
                                                         48'(st5_d_reg - st5_c_reg);
            st6_den_b_reg <= 48'(st5_c_reg) + 48'(st5_d_reg);
        end
    end

    // stage 7: find the shift that brings each denominator below 2^31
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st7_vld_reg <= 1'b0;
        end else if (en) begin
            st7_vld_reg <= st6_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st7_graze_reg <= st6_graze_reg;
            st7_num_a_reg <= st6_num_a_reg;
            st7_den_a_reg <= st6_den_a_reg;
            st7_num_b_reg <= st6_num_b_reg;
            st7_den_b_reg <= st6_den_b_reg;
            st7_sh_a_reg  <= norm_shift(st6_den_a_reg);
            st7_sh_b_reg  <= norm_shift(st6_den_b_reg);
        end
    end

    // shift both operands, then settle the integer quotient bit (num <= den)
    always_comb begin
        sh_num_a = st7_num_a_reg >> st7_sh_a_reg;
        sh_den_a = st7_den_a_reg >> st7_sh_a_reg;
        sh_num_b = st7_num_b_reg >> st7_sh_b_reg;
        sh_den_b = st7_den_b_reg >> st7_sh_b_reg;
        nm_a = sh_num_a[31:0];
        dn_a = sh_den_a[31:0];
        nm_b = sh_num_b[31:0];
        dn_b = sh_den_b[31:0];
        ge_a = (nm_a >= dn_a);
        ge_b = (nm_b >= dn_b);
        rdiv_a_link[0].rem = ge_a ? (nm_a - dn_a) : nm_a;
        rdiv_a_link[0].quo = {35'd0, ge_a};
        rdiv_a_link[0].dvd = '0;
        rdiv_a_link[0].dvs = dn_a;
        rdiv_b_link[0].rem = ge_b ? (nm_b - dn_b) : nm_b;
        rdiv_b_link[0].quo = {35'd0, ge_b};
        rdiv_b_link[0].dvd = '0;
        rdiv_b_link[0].dvs = dn_b;
    end

    for (genvar g = 0; g < RDIV_STEPS; g++) begin : g_rdiv
        fdr_div_cell u_cell_a (
            .aclk     (aclk),
            .en       (en),
            .cell_in  (rdiv_a_link[g]),
            .cell_out (rdiv_a_link[g+1])
        );
        fdr_div_cell u_cell_b (
            .aclk     (aclk),
            .en       (en),
            .cell_in  (rdiv_b_link[g]),
            .cell_out (rdiv_b_link[g+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rdiv_vld_reg <= '0;
        end else if (en) begin
            rdiv_vld_reg <= {rdiv_vld_reg[RDIV_STEPS-2:0], st7_vld_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rdiv_graze_reg <= {rdiv_graze_reg[RDIV_STEPS-2:0], st7_graze_reg};
        end
    end

    // stage 8: square each Q31 ratio to Q62
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st8_vld_reg <= 1'b0;
        end else if (en) begin
            st8_vld_reg <= rdiv_vld_reg[RDIV_STEPS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st8_graze_reg <= rdiv_graze_reg[RDIV_STEPS-1];
            st8_sq_a_reg  <= rdiv_a_link[RDIV_STEPS].quo[31:0] *
                             rdiv_a_link[RDIV_STEPS].quo[31:0];
            st8_sq_b_reg  <= rdiv_b_link[RDIV_STEPS].quo[31:0] *
                             rdiv_b_link[RDIV_STEPS].quo[31:0];
        end
    end

    // mean of both squares, rounded to Q16; grazing forces full reflection
    assign sum = st8_sq_a_reg + st8_sq_b_reg + (64'd1 << 46);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= st8_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_refl_reg <= st8_graze_reg ? 17'd65536 : sum[63:47];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_refl_reg};

endmodule
`default_nettype wire

[design/fdr_checker.sv]
`default_nettype none
`include "assert_macros.svh"
module fdr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [111:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);
    `FDR_ASSERT_RST(a_reset_clears_out, !aresetn, !m_tvalid)
    `FDR_ASSERT_NXT(a_out_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `FDR_ASSERT_IMP(a_refl_range, m_tvalid, m_tdata[16:0] <= 17'd65536 && m_tdata[23:17] == 7'd0)
    `FDR_ASSERT_IMP(a_stall_blocks_in, m_tvalid && !m_tready, !s_tready)

endmodule

bind fresnel_dielectric_reflectance_top fdr_checker u_fdr_checker (.*);
`default_nettype wire
